// ===== rtl/can_message_segmenter_macros.svh =====
// ----------------------------------------------------------------------------
// can_message_segmenter assertion macros
// Clocked on i_clk, checks off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CAN_MESSAGE_SEGMENTER_MACROS_SVH
`define CAN_MESSAGE_SEGMENTER_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge out of reset
`define CMS_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("cms assertion failed");

// expression must never be true
`define CMS_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("cms forbidden condition seen");

`else

`define CMS_ASSERT(label, prop)
`define CMS_ASSERT_NEVER(label, expr)

`endif

`endif

// ===== rtl/cms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cms_pkg
// Shared types and constants of the CAN message segmenter.
// ----------------------------------------------------------------------------
package cms_pkg;

    localparam int BYTE_W       = 8;
    localparam int FRAME_BYTES  = 8;
    localparam int HEADER_BYTES = 3;
    localparam int CHUNK_BYTES  = FRAME_BYTES - HEADER_BYTES;
    localparam int LEN_W        = 4;
    localparam int FILL_W       = 4;
    localparam int IDX_W        = 3;
    localparam int ID_BITS      = 11;
    localparam int FRAME_ID_W   = 11;
    localparam int DATA_W       = BYTE_W * FRAME_BYTES;

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // header byte codes
    localparam logic [BYTE_W-1:0] TAG_RESET  = 8'h32;
    localparam logic [BYTE_W-1:0] FLAG_FINAL = 8'h31;
    localparam logic [BYTE_W-1:0] FLAG_MORE  = 8'h30;

    // one outgoing frame, without its id
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] data;
    } t_frame;

endpackage

// ===== rtl/cms_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cms_front
// Takes message bytes, buffers them, and builds raw or segmented frames.
// Emits at most one frame word per accepted byte; a second frame due in the
// same step is held back and goes out with the next byte.
// ----------------------------------------------------------------------------
`include "can_message_segmenter_macros.svh"

module cms_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [cms_pkg::BYTE_W-1:0]    i_data_byte,
    input  logic                          i_last_byte,
    input  logic                          i_cfg_we,
    input  logic [cms_pkg::BYTE_W-1:0]    i_cfg_wdata,
    input  logic                          i_q_full,
    output logic                          o_in_stall,
    output logic                          o_push,
    output cms_pkg::t_frame               o_frame
);

    // message buffer and control
    logic [cms_pkg::BYTE_W-1:0] r_store [0:cms_pkg::FRAME_BYTES-1];
    logic [cms_pkg::FILL_W-1:0] r_fill, n_fill;
    logic                       r_seg, n_seg;
    logic [cms_pkg::BYTE_W-1:0] r_line;
    logic [cms_pkg::BYTE_W-1:0] r_tag_char;
    logic                       r_carry_valid, n_carry_valid;
    cms_pkg::t_frame            r_carry, n_carry;

    logic                       accept;
    logic                       trans;
    logic                       seg_full;
    logic                       more_push;
    logic                       chunk_path;
    logic [cms_pkg::IDX_W-1:0]  widx;
    logic [cms_pkg::DATA_W-1:0] raw_data;
    logic [cms_pkg::DATA_W-1:0] more_data;
    logic [cms_pkg::DATA_W-1:0] chunk_data;
    logic [cms_pkg::BYTE_W-1:0] fin_line;
    cms_pkg::t_frame            more_frame;
    cms_pkg::t_frame            fin_frame;
    cms_pkg::t_frame            p0_frame;
    logic                       p0_valid;
    logic                       p1_valid;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    // step classification
    assign trans      = !r_seg && r_fill[cms_pkg::FILL_W-1];
    assign seg_full   = r_seg && (r_fill == cms_pkg::FILL_W'(cms_pkg::CHUNK_BYTES));
    assign more_push  = trans || seg_full;
    assign chunk_path = r_seg || trans;
    assign widx       = more_push ? '0 : r_fill[cms_pkg::IDX_W-1:0];
    assign fin_line   = trans ? r_store[2] : r_line;

    // short message sent unchanged
    always_comb begin
        raw_data = '0;
        for (int i = 0; i < cms_pkg::FRAME_BYTES; i++) begin
            if (cms_pkg::FILL_W'(i) < r_fill) begin
                raw_data[cms_pkg::BYTE_W*i +: cms_pkg::BYTE_W] = r_store[i];
            end else if (cms_pkg::FILL_W'(i) == r_fill) begin
                raw_data[cms_pkg::BYTE_W*i +: cms_pkg::BYTE_W] = i_data_byte;
            end
        end
    end

    // full chunk with more to come
    always_comb begin
        more_data = '0;
        more_data[0 +: cms_pkg::BYTE_W]                = r_tag_char;
        more_data[cms_pkg::BYTE_W +: cms_pkg::BYTE_W]  = cms_pkg::FLAG_MORE;
        more_data[2*cms_pkg::BYTE_W +: cms_pkg::BYTE_W] = fin_line;
        for (int j = 0; j < cms_pkg::CHUNK_BYTES; j++) begin
            more_data[cms_pkg::BYTE_W*(cms_pkg::HEADER_BYTES+j) +: cms_pkg::BYTE_W] =
                trans ? r_store[cms_pkg::HEADER_BYTES+j] : r_store[j];
        end
    end

    // final chunk: held bytes plus this byte
    always_comb begin
        chunk_data = '0;
        chunk_data[0 +: cms_pkg::BYTE_W]                 = r_tag_char;
        chunk_data[cms_pkg::BYTE_W +: cms_pkg::BYTE_W]   = cms_pkg::FLAG_FINAL;
        chunk_data[2*cms_pkg::BYTE_W +: cms_pkg::BYTE_W] = fin_line;
        for (int j = 0; j < cms_pkg::CHUNK_BYTES; j++) begin
            if (cms_pkg::IDX_W'(j) < widx) begin
                chunk_data[cms_pkg::BYTE_W*(cms_pkg::HEADER_BYTES+j) +: cms_pkg::BYTE_W] =
                    r_store[j];
            end else if (cms_pkg::IDX_W'(j) == widx) begin
                chunk_data[cms_pkg::BYTE_W*(cms_pkg::HEADER_BYTES+j) +: cms_pkg::BYTE_W] =
                    i_data_byte;
            end
        end
    end

    always_comb begin
        more_frame.len  = cms_pkg::LEN_W'(cms_pkg::FRAME_BYTES);
        more_frame.data = more_data;
        if (chunk_path) begin
            fin_frame.len  = cms_pkg::LEN_W'(widx) + cms_pkg::LEN_W'(cms_pkg::HEADER_BYTES + 1);
            fin_frame.data = chunk_data;
        end else begin
            fin_frame.len  = r_fill + cms_pkg::LEN_W'(1);
            fin_frame.data = raw_data;
        end
    end

    // frames due this step, oldest first
    assign p0_valid = more_push || i_last_byte;
    assign p1_valid = more_push && i_last_byte;
    assign p0_frame = more_push ? more_frame : fin_frame;

    // pick the word sent now, hold back the rest
    always_comb begin
        n_carry_valid = r_carry_valid;
        n_carry       = r_carry;
        o_push        = 1'b0;
        o_frame       = p0_frame;
        if (accept) begin
            if (r_carry_valid) begin
                o_push        = 1'b1;
                o_frame       = r_carry;
                n_carry_valid = p0_valid;
                n_carry       = p0_frame;
            end else begin
                o_push        = p0_valid;
                n_carry_valid = p1_valid;
                n_carry       = fin_frame;
            end
        end
    end

    // buffer bookkeeping
    always_comb begin
        n_fill = r_fill;
        n_seg  = r_seg;
        if (accept) begin
            n_fill = i_last_byte ? '0 : cms_pkg::FILL_W'(widx) + cms_pkg::FILL_W'(1);
            n_seg  = chunk_path && !i_last_byte;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill        <= '0;
            r_seg         <= 1'b0;
            r_carry_valid <= 1'b0;
            r_tag_char    <= cms_pkg::TAG_RESET;
        end else begin
            r_fill        <= n_fill;
            r_seg         <= n_seg;
            r_carry_valid <= n_carry_valid;
            if (i_cfg_we) begin
                r_tag_char <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_carry <= n_carry;
        if (accept) begin
            r_store[widx] <= i_data_byte;
            if (trans) begin
                r_line <= r_store[2];
            end
        end
    end

    // held-back frame never meets two new frames in one step
    `CMS_ASSERT_NEVER(a_carry_overrun, accept && r_carry_valid && p1_valid)
    // a chunk never grows past its size
    `CMS_ASSERT(a_chunk_bound, r_seg |-> (r_fill <= cms_pkg::FILL_W'(cms_pkg::CHUNK_BYTES)))

endmodule

// ===== rtl/cms_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cms_fifo
// Short frame queue between the front and the back.
// ----------------------------------------------------------------------------
`include "can_message_segmenter_macros.svh"

module cms_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cms_pkg::t_frame i_frame,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output cms_pkg::t_frame o_frame
);

    cms_pkg::t_frame              r_mem [0:cms_pkg::Q_DEPTH-1];
    logic [cms_pkg::Q_PTR_W-1:0]  r_wr_ptr;
    logic [cms_pkg::Q_PTR_W-1:0]  r_rd_ptr;
    logic [cms_pkg::Q_CNT_W-1:0]  r_count, n_count;

    assign o_full  = (r_count == cms_pkg::Q_CNT_W'(cms_pkg::Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_frame = r_mem[r_rd_ptr];

    // occupancy
    always_comb begin
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + cms_pkg::Q_CNT_W'(1);
            2'b01:   n_count = r_count - cms_pkg::Q_CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + cms_pkg::Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + cms_pkg::Q_PTR_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

    // no overflow, no underflow
    `CMS_ASSERT_NEVER(a_q_overflow, (i_push && o_full) || (i_pop && o_empty))

endmodule

// ===== rtl/cms_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cms_back
// Takes frames off the queue, stamps the next id and holds the output word.
// ----------------------------------------------------------------------------
`include "can_message_segmenter_macros.svh"

module cms_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_empty,
    input  cms_pkg::t_frame                   i_frame,
    input  logic                              i_out_stall,
    output logic                              o_pop,
    output logic                              o_out_valid,
    output logic [cms_pkg::FRAME_ID_W-1:0]    o_frame_id,
    output logic [cms_pkg::LEN_W-1:0]         o_frame_length,
    output logic [cms_pkg::DATA_W-1:0]        o_frame_bytes
);

    logic                           r_valid;
    logic [cms_pkg::ID_BITS-1:0]    r_cnt;
    logic [cms_pkg::FRAME_ID_W-1:0] r_id;
    cms_pkg::t_frame                r_frame;
    logic                           load;

    // output register free or being taken
    assign load  = !r_valid || !i_out_stall;
    assign o_pop = load && !i_q_empty;

    assign o_out_valid    = r_valid;
    assign o_frame_id     = r_id;
    assign o_frame_length = r_frame.len;
    assign o_frame_bytes  = r_frame.data;

    // valid and id counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            if (load) begin
                r_valid <= !i_q_empty;
            end
            if (o_pop) begin
                r_cnt <= r_cnt + cms_pkg::ID_BITS'(1);
            end
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_frame <= i_frame;
            r_id    <= r_cnt[cms_pkg::FRAME_ID_W-1:0];
        end
    end

    // every frame sent takes exactly the next id
    `CMS_ASSERT(a_id_step, o_pop |=> (r_cnt == $past(r_cnt) + cms_pkg::ID_BITS'(1)))

endmodule

// ===== rtl/can_message_segmenter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_message_segmenter
// Turns a byte stream of messages into CAN frames: short messages as one
// frame, longer ones as tagged chunks with a line number.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                fields
//  in        in   i_in_valid / o_in_stall  i_data_byte, i_last_byte
//  out       out  o_out_valid / i_out_stall o_frame_id, o_frame_length,
//                                          o_frame_bytes
//  cfg       in   i_cfg_we                 i_cfg_wdata (tag byte)
//
// One byte can be taken every clock while o_in_stall is low; each byte yields
// zero or one frame word. A frame word enters the queue at the edge that takes
// its byte and moves to the output once it heads the queue and the output is
// free; a second frame due on the same byte waits for the next byte taken.
// o_in_stall rises only when the 4-entry frame queue is full.
// Reset is synchronous, active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
module can_message_segmenter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [cms_pkg::BYTE_W-1:0]        i_data_byte,
    input  logic                              i_last_byte,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [cms_pkg::FRAME_ID_W-1:0]    o_frame_id,
    output logic [cms_pkg::LEN_W-1:0]         o_frame_length,
    output logic [cms_pkg::DATA_W-1:0]        o_frame_bytes,
    input  logic                              i_cfg_we,
    input  logic [cms_pkg::BYTE_W-1:0]        i_cfg_wdata
);

    logic            q_full;
    logic            q_empty;
    logic            q_push;
    logic            q_pop;
    cms_pkg::t_frame push_frame;
    cms_pkg::t_frame head_frame;

    // byte intake and frame building
    cms_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_full    (q_full),
        .o_in_stall  (o_in_stall),
        .o_push      (q_push),
        .o_frame     (push_frame)
    );

    // frame queue
    cms_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_frame (push_frame),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_frame (head_frame)
    );

    // id stamping and output register
    cms_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_frame        (head_frame),
        .i_out_stall    (i_out_stall),
        .o_pop          (q_pop),
        .o_out_valid    (o_out_valid),
        .o_frame_id     (o_frame_id),
        .o_frame_length (o_frame_length),
        .o_frame_bytes  (o_frame_bytes)
    );

endmodule
